// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        key_t   key;
        value_t value;
    } entry_t;

    // result of the shared key comparator
    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_t;

endpackage

// ===== rtl/spq_ram.sv =====
module spq_ram
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/spq_cmp.sv =====
module spq_cmp
    import spq_pkg::*;
(
    input  key_t a,
    input  key_t b,
    output cmp_t res
);

    assign res.gt = (a > b);
    assign res.eq = (a == b);

endmodule

// ===== rtl/sorted_priority_queue_with_update_top.sv =====
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  operation, key, value
// result    out        out_valid / out_stall ok, replaced, out_key, out_value
//
// An enqueue scans the stored entries (up to the count) and then moves the entries
// below its place down; a dequeue reads the head and moves any later entries up.
// The single read port of the entry memory sets the pace: one entry per cycle,
// through one shared key comparator.
// Reset empties the queue at once; the memory contents are left as they are.
// in_stall is high while a request is being worked on; a finished result waits
// in the output register, and a new request is taken while it waits.
module sorted_priority_queue_with_update_top
    import spq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   operation,
    input  key_t   key,
    input  value_t value,
    output logic   out_valid,
    input  logic   out_stall,
    output logic   ok,
    output logic   replaced,
    output key_t   out_key,
    output value_t out_value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_PUT,
        ST_DQ_HEAD,
        ST_DQ_SHIFT,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  sh_reg, sh_next;
    key_t              k_reg, k_next;
    value_t            v_reg, v_next;
    logic              rep_reg, rep_next;

    // result held until the output register is free
    logic              res_ok_reg, res_ok_next;
    logic              res_rep_reg, res_rep_next;
    key_t              res_key_reg, res_key_next;
    value_t            res_val_reg, res_val_next;

    logic              out_valid_reg, out_valid_next;
    logic              ok_reg, ok_next;
    logic              replaced_reg, replaced_next;
    key_t              out_key_reg, out_key_next;
    value_t            out_value_reg, out_value_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [CNT_W-1:0]  rd_addr;
    entry_t            rd_data;
    cmp_t              cmp;

    logic [CNT_W-1:0]  scan_inc;
    logic [CNT_W-1:0]  ins_pos;

    spq_ram
    #(
        .DEPTH (CAPACITY),
        .WIDTH ($bits(entry_t))
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // shared comparator: stored key against the requested key
    spq_cmp u_cmp
    (
        .a   (rd_data.key),
        .b   (k_reg),
        .res (cmp)
    );

    assign scan_inc = scan_reg + CNT_W'(1);
    assign ins_pos  = cmp.gt ? scan_inc : scan_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        sh_next        = sh_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        rep_next       = rep_reg;
        res_ok_next    = res_ok_reg;
        res_rep_next   = res_rep_reg;
        res_key_next   = res_key_reg;
        res_val_next   = res_val_reg;
        ok_next        = ok_reg;
        replaced_next  = replaced_reg;
        out_key_next   = out_key_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = pos_reg[IDX_W-1:0];
        wr_data        = '{key: k_reg, value: v_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    k_next   = key;
                    v_next   = value;
                    rep_next = 1'b0;
                    scan_next = '0;
                    pos_next  = '0;
                    if (count_reg == '0)
                    begin
                        if (operation == OP_DEQ)
                        begin
                            // empty queue: refuse
                            res_ok_next  = 1'b0;
                            res_rep_next = 1'b0;
                            res_key_next = '0;
                            res_val_next = '0;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                    else if (operation == OP_DEQ)
                    begin
                        state_next = ST_DQ_HEAD;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (cmp.gt && (scan_inc != count_reg))
                begin
                    // advance to the next stored entry
                    scan_next = scan_inc;
                    rd_addr   = scan_inc;
                end
                else if (cmp.eq)
                begin
                    rep_next   = 1'b1;
                    pos_next   = scan_reg;
                    state_next = ST_PUT;
                end
                else if (count_reg == FULL_CNT)
                begin
                    res_ok_next  = 1'b0;
                    res_rep_next = 1'b0;
                    res_key_next = '0;
                    res_val_next = '0;
                    state_next   = ST_DONE;
                end
                else if (ins_pos == count_reg)
                begin
                    pos_next   = ins_pos;
                    state_next = ST_PUT;
                end
                else
                begin
                    pos_next   = ins_pos;
                    sh_next    = count_reg;
                    rd_addr    = count_reg - CNT_W'(1);
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // move entry sh-1 down to sh
                wr_en   = 1'b1;
                wr_addr = sh_reg[IDX_W-1:0];
                wr_data = rd_data;
                rd_addr = sh_reg - CNT_W'(2);
                sh_next = sh_reg - CNT_W'(1);
                if ((sh_reg - CNT_W'(1)) == pos_reg)
                begin
                    state_next = ST_PUT;
                end
            end

            ST_PUT:
            begin
                wr_en        = 1'b1;
                res_ok_next  = 1'b1;
                res_rep_next = rep_reg;
                res_key_next = k_reg;
                res_val_next = v_reg;
                if (!rep_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_DONE;
            end

            ST_DQ_HEAD:
            begin
                res_ok_next  = 1'b1;
                res_rep_next = 1'b0;
                res_key_next = rd_data.key;
                res_val_next = rd_data.value;
                if (count_reg == CNT_W'(1))
                begin
                    count_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr    = CNT_W'(1);
                    sh_next    = CNT_W'(1);
                    state_next = ST_DQ_SHIFT;
                end
            end

            ST_DQ_SHIFT:
            begin
                // move entry sh up to sh-1
                wr_en   = 1'b1;
                wr_addr = sh_reg[IDX_W-1:0] - IDX_W'(1);
                wr_data = rd_data;
                rd_addr = sh_reg + CNT_W'(1);
                sh_next = sh_reg + CNT_W'(1);
                if ((sh_reg + CNT_W'(1)) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    replaced_next  = res_rep_reg;
                    out_key_next   = res_key_reg;
                    out_value_next = res_val_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            scan_reg      <= scan_next;
            pos_reg       <= pos_next;
            sh_reg        <= sh_next;
            k_reg         <= k_next;
            v_reg         <= v_next;
            rep_reg       <= rep_next;
            res_ok_reg    <= res_ok_next;
            res_rep_reg   <= res_rep_next;
            res_key_reg   <= res_key_next;
            res_val_reg   <= res_val_next;
            ok_reg        <= ok_next;
            replaced_reg  <= replaced_next;
            out_key_reg   <= out_key_next;
            out_value_reg <= out_value_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign replaced  = replaced_reg;
    assign out_key   = out_key_reg;
    assign out_value = out_value_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_W'(1)) ||
             (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("entry count moved by more than one");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (!replaced && (out_key == '0) && (out_value == '0)))
        else $error("refused request carries data");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside completion");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !wr_en)
        else $error("memory written while no request in progress");
`endif

endmodule
